// File: rtl/imwdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imwdr_pkg
// Shared constants and types of the IMU window dead-reckoning block.
// ----------------------------------------------------------------------------
package imwdr_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int NUM_W           = 64;
    localparam int DEN_W           = 30;
    localparam int WS_W            = 9;
    localparam int BIAS_W          = 18;
    localparam int HOME_W          = 48;
    localparam int CLEAN_OUT_W     = 19;
    localparam int ANGLE_W         = 10;
    localparam int POS_W           = 64;
    localparam int OUT_W           = 6 * CLEAN_OUT_W + 3 * POS_W + 3 * ANGLE_W;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    localparam int G_Q16           = 643537;  // 9.8196 in Q.16
    localparam int TIME_BASE       = 500;
    localparam int ACC_DIV_SHIFT   = 12;      // 2 * 2048
    localparam int DEG_DIV_UNIT    = 655;
    localparam int DEG_MOD_UNIT    = 23580;   // 360 * 655 / 10
    localparam int DEG_MUL         = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_BIAS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_Z      = 3'd5;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;   // signed dividend
        logic [DEN_W-1:0] den;   // unsigned divisor, never zero
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;   // truncated toward zero
        logic [DEN_W:0]   rem;   // sign follows the dividend
    } t_div_rsp;

endpackage
`default_nettype wire

// File: rtl/imwdr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imwdr_div
// Bit-serial signed-by-unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module imwdr_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire imwdr_pkg::t_div_req  i_req,
    output imwdr_pkg::t_div_rsp       o_rsp
);
    import imwdr_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [6:0]       r_cnt;
    logic             r_neg;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_q[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(NUM_W);
                r_neg  <= i_req.num[NUM_W-1];
                r_q    <= i_req.num[NUM_W-1] ? -i_req.num : i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_q   <= {r_q[NUM_W-2:0], ge};
                r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -r_q : r_q;
    assign o_rsp.rem  = r_neg ? -{1'b0, r_rem} : {1'b0, r_rem};

endmodule
`default_nettype wire

// File: rtl/imwdr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imwdr_queue
// Two-entry queue of finished window sums between the front and back parts.
// ----------------------------------------------------------------------------
module imwdr_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_mem[r_rd];

endmodule
`default_nettype wire

// File: rtl/imwdr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imwdr_front
// Accepts samples, accumulates the six channel sums and closes windows.
// ----------------------------------------------------------------------------
module imwdr_front #(
    parameter int SAMPLE_BITS = imwdr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [6*SAMPLE_BITS-1:0]           i_samples,
    input  wire logic [imwdr_pkg::WS_W-1:0]         i_window_size,
    input  wire logic                               i_full,
    output logic                                    o_push,
    output logic [6*(SAMPLE_BITS+9)+imwdr_pkg::WS_W-1:0] o_entry
);
    import imwdr_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + 9;

    logic signed [SUM_W-1:0] r_sum [6];
    logic signed [SUM_W-1:0] n_sum [6];
    logic [WS_W-1:0]         r_cnt;
    logic [WS_W-1:0]         n_cnt;
    logic [WS_W-1:0]         ws_eff;
    logic                    accept;
    logic                    close;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign ws_eff  = (i_window_size == '0) ? WS_W'(1) : i_window_size;
    assign n_cnt   = r_cnt + WS_W'(1);
    assign close   = n_cnt >= ws_eff;
    assign o_push  = accept && close;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_sum[k] = r_sum[k]
                + SUM_W'(signed'(i_samples[k*SAMPLE_BITS +: SAMPLE_BITS]));
            o_entry[k*SUM_W +: SUM_W] = n_sum[k];
        end
        o_entry[6*SUM_W +: WS_W] = ws_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int k = 0; k < 6; k++) begin
                r_sum[k] <= '0;
            end
        end else if (accept) begin
            r_cnt <= close ? '0 : n_cnt;
            for (int k = 0; k < 6; k++) begin
                r_sum[k] <= close ? '0 : n_sum[k];
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/imwdr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imwdr_back
// Window sequencer: means, cleaning, integration, position and angles.
// ----------------------------------------------------------------------------
module imwdr_back #(
    parameter int SAMPLE_BITS = imwdr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_empty,
    input  wire logic [6*(SAMPLE_BITS+9)+imwdr_pkg::WS_W-1:0] i_entry,
    output logic                                    o_pop,
    input  wire logic [3*imwdr_pkg::BIAS_W-1:0]     i_accel_bias,
    input  wire logic [3*imwdr_pkg::BIAS_W-1:0]     i_gyro_bias,
    input  wire logic [3*imwdr_pkg::HOME_W-1:0]     i_home,
    output imwdr_pkg::t_div_req                     o_div_req,
    input  wire imwdr_pkg::t_div_rsp                i_div_rsp,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [imwdr_pkg::OUT_W-1:0]             o_data
);
    import imwdr_pkg::*;

    localparam int SUM_W   = SAMPLE_BITS + 9;
    localparam int CLEAN_W = ((SAMPLE_BITS > BIAS_W) ? SAMPLE_BITS : BIAS_W) + 2;
    localparam logic [19:0] G_C = 20'(G_Q16);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_MEAN = 13'b0000000000010,
        S_TDIV = 13'b0000000000100,
        S_TMUL = 13'b0000000001000,
        S_ACC  = 13'b0000000010000,
        S_NUM  = 13'b0000000100000,
        S_PDIV = 13'b0000001000000,
        S_MUL0 = 13'b0000010000000,
        S_MUL1 = 13'b0000100000000,
        S_POS  = 13'b0001000000000,
        S_GMOD = 13'b0010000000000,
        S_ANG  = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;

    t_state                    r_state;
    t_div_req                  r_req;
    logic signed [SUM_W-1:0]   r_sums [6];
    logic [WS_W-1:0]           r_ws;
    logic [2:0]                r_ch;
    logic [1:0]                r_ax;
    logic signed [SAMPLE_BITS-1:0] r_mean [6];
    logic [WS_W-1:0]           r_t;
    logic [DEN_W-1:0]          r_pdiv;
    logic [DEN_W-1:0]          r_degdiv;
    logic [DEN_W-1:0]          r_degmod;
    logic signed [CLEAN_W-1:0] r_aclean [3];
    logic signed [CLEAN_W-1:0] r_gclean [3];
    logic [NUM_W-1:0]          r_acc [3];
    logic [NUM_W-1:0]          r_vel [3];
    logic signed [31:0]        r_gyro [3];
    logic [NUM_W-1:0]          r_q;
    logic [51:0]               r_plo;
    logic [31:0]               r_phi;
    logic [POS_W-1:0]          r_pos [3];
    logic [ANGLE_W-1:0]        r_angle [3];
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_out_data;

    logic signed [CLEAN_W-1:0] m_ext [6];
    logic signed [CLEAN_W-1:0] ab [3];
    logic signed [CLEAN_W-1:0] gb [3];
    logic [2*WS_W-1:0]         tt;
    logic [51:0]               plo_w;
    logic [51:0]               phi_w;
    logic signed [NUM_W-1:0]   rem_ext;
    logic [OUT_W-1:0]          pack;
    logic                      load_out;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            m_ext[k] = CLEAN_W'(r_mean[k]);
        end
        for (int k = 0; k < 3; k++) begin
            ab[k] = CLEAN_W'(signed'(i_accel_bias[k*BIAS_W +: BIAS_W]));
            gb[k] = CLEAN_W'(signed'(i_gyro_bias[k*BIAS_W +: BIAS_W]));
        end
    end

    assign tt      = r_t * r_t;
    assign plo_w   = r_q[31:0] * G_C;
    assign phi_w   = r_q[63:32] * G_C;
    assign rem_ext = NUM_W'(signed'(i_div_rsp.rem));
    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign load_out = (r_state == S_OUT) && (!r_out_valid || i_ready);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pack[k*CLEAN_OUT_W +: CLEAN_OUT_W]       = r_aclean[k][CLEAN_OUT_W-1:0];
            pack[(3+k)*CLEAN_OUT_W +: CLEAN_OUT_W]   = r_gclean[k][CLEAN_OUT_W-1:0];
            pack[6*CLEAN_OUT_W + k*POS_W +: POS_W]   = r_pos[k];
            pack[6*CLEAN_OUT_W + 3*POS_W + k*ANGLE_W +: ANGLE_W] = r_angle[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_acc[k]  <= '0;
                r_vel[k]  <= '0;
                r_gyro[k] <= '0;
            end
        end else begin
            r_req.start <= 1'b0;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        for (int k = 0; k < 6; k++) begin
                            r_sums[k] <= i_entry[k*SUM_W +: SUM_W];
                        end
                        r_ws        <= i_entry[6*SUM_W +: WS_W];
                        r_ch        <= '0;
                        r_req.start <= 1'b1;
                        r_req.num   <= NUM_W'(signed'(i_entry[0 +: SUM_W]));
                        r_req.den   <= DEN_W'(i_entry[6*SUM_W +: WS_W]);
                        r_state     <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (i_div_rsp.done) begin
                        r_mean[r_ch] <= i_div_rsp.quo[SAMPLE_BITS-1:0];
                        r_req.start  <= 1'b1;
                        r_req.den    <= DEN_W'(r_ws);
                        if (r_ch == 3'd5) begin
                            r_req.num <= NUM_W'(TIME_BASE);
                            r_state   <= S_TDIV;
                        end else begin
                            r_ch      <= r_ch + 3'd1;
                            r_req.num <= NUM_W'(r_sums[r_ch + 3'd1]);
                        end
                    end
                end
                S_TDIV: begin
                    if (i_div_rsp.done) begin
                        r_t <= (i_div_rsp.quo == '0) ? WS_W'(1)
                                                     : i_div_rsp.quo[WS_W-1:0];
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    r_pdiv   <= {tt, ACC_DIV_SHIFT'(0)};
                    r_degdiv <= DEN_W'(r_t) * DEN_W'(DEG_DIV_UNIT);
                    r_degmod <= DEN_W'(r_t) * DEN_W'(DEG_MOD_UNIT);
                    r_aclean[0] <= m_ext[1] - ab[0];
                    r_aclean[1] <= -m_ext[0] - ab[1];
                    r_aclean[2] <= m_ext[2] - ab[2];
                    for (int k = 0; k < 3; k++) begin
                        r_gclean[k] <= -m_ext[3+k] - gb[k];
                    end
                    r_ax    <= '0;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc[r_ax] <= r_acc[r_ax] + NUM_W'(r_aclean[r_ax]);
                    r_state     <= S_NUM;
                end
                S_NUM: begin
                    r_req.start <= 1'b1;
                    r_req.num   <= {r_vel[r_ax][NUM_W-2:0], 1'b0} + r_acc[r_ax];
                    r_req.den   <= r_pdiv;
                    r_state     <= S_PDIV;
                end
                S_PDIV: begin
                    if (i_div_rsp.done) begin
                        r_q     <= i_div_rsp.quo;
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_plo   <= plo_w;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_phi   <= phi_w[31:0];
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_pos[r_ax] <= NUM_W'(signed'(i_home[r_ax*HOME_W +: HOME_W]))
                                 + NUM_W'(r_plo) + {r_phi, 32'd0};
                    r_vel[r_ax] <= r_vel[r_ax] + r_acc[r_ax];
                    r_req.start <= 1'b1;
                    r_req.num   <= NUM_W'(r_gyro[r_ax]) + NUM_W'(r_gclean[r_ax])
                                 + NUM_W'(r_degmod);
                    r_req.den   <= r_degmod;
                    r_state     <= S_GMOD;
                end
                S_GMOD: begin
                    if (i_div_rsp.done) begin
                        r_gyro[r_ax] <= 32'(signed'(i_div_rsp.rem));
                        r_req.start  <= 1'b1;
                        r_req.num    <= (rem_ext <<< 3) + (rem_ext <<< 1);
                        r_req.den    <= r_degdiv;
                        r_state      <= S_ANG;
                    end
                end
                S_ANG: begin
                    if (i_div_rsp.done) begin
                        r_angle[r_ax] <= i_div_rsp.quo[ANGLE_W-1:0];
                        if (r_ax == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= S_ACC;
                        end
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= pack;
        end
    end

    assign o_div_req = r_req;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out_data;

endmodule
`default_nettype wire

// File: rtl/imu_window_dead_reckoning.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_window_dead_reckoning
// Windowed IMU averaging with double integration into a Q.16 position.
// ----------------------------------------------------------------------------
// Samples enter on the s_axis channel, one word per sample holding the three
// accelerometer and three gyro channels. Every window_size samples close a
// window, and one result word leaves on the m_axis channel with the cleaned
// means, the world position and the whole-degree angles.
// The front keeps summing samples while the back works on earlier windows,
// with a two-entry queue between them. Each window costs the back 16 serial
// divisions on the shared one-bit-per-cycle divider plus the multiply and update
// steps. The front stalls whenever the queue is full, until the back takes the
// oldest window.
// Configuration words on the cfg channel are always accepted; index 0 is the
// window size, 1 and 2 the packed biases, 3 to 5 the home position.
// Reset clears the sums, the count and all integrals at once and restores the
// default window size of 10. When the receiver stalls, the finished result
// holds in the output register and the back waits with its next result.
// ----------------------------------------------------------------------------
module imu_window_dead_reckoning #(
    parameter int SAMPLE_BITS = imwdr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // accel_ch0, accel_ch1, accel_ch2, gyro_ch0, gyro_ch1, gyro_ch2, zero pad
    input  wire logic [((6*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // accel_clean_x/y/z, gyro_clean_x/y/z, pos_x/y/z, angle_x/y/z
    output logic [imwdr_pkg::OUT_W-1:0]                m_axis_tdata,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [imwdr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [imwdr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import imwdr_pkg::*;

    localparam int SUM_W   = SAMPLE_BITS + 9;
    localparam int ENTRY_W = 6 * SUM_W + WS_W;

    logic [WS_W-1:0]     r_window_size;
    logic [3*BIAS_W-1:0] r_accel_bias;
    logic [3*BIAS_W-1:0] r_gyro_bias;
    logic [3*HOME_W-1:0] r_home;

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    // The configuration port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WS_W'(10);
            r_accel_bias  <= '0;
            r_gyro_bias   <= '0;
            r_home        <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[WS_W-1:0];
                CFG_ACCEL_BIAS:  r_accel_bias  <= i_cfg_data[3*BIAS_W-1:0];
                CFG_GYRO_BIAS:   r_gyro_bias   <= i_cfg_data[3*BIAS_W-1:0];
                CFG_HOME_X:      r_home[0*HOME_W +: HOME_W] <= i_cfg_data[HOME_W-1:0];
                CFG_HOME_Y:      r_home[1*HOME_W +: HOME_W] <= i_cfg_data[HOME_W-1:0];
                CFG_HOME_Z:      r_home[2*HOME_W +: HOME_W] <= i_cfg_data[HOME_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: accumulates samples and hands each closed window to the queue.
    imwdr_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_samples     (s_axis_tdata[6*SAMPLE_BITS-1:0]),
        .i_window_size (r_window_size),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_entry       (q_wdata)
    );

    imwdr_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // Back: one window at a time through the shared divider.
    imwdr_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_entry      (q_rdata),
        .o_pop        (q_pop),
        .i_accel_bias (r_accel_bias),
        .i_gyro_bias  (r_gyro_bias),
        .i_home       (r_home),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata)
    );

    imwdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule
`default_nettype wire
